@@ src/csvfs_pkg.sv @@
`default_nettype none

package csvfs_pkg;

   // default counter widths
   localparam int DEFAULT_COLUMN_BITS = 8;
   localparam int DEFAULT_ROW_BITS    = 16;

   // byte codes the parser looks for
   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   // single-bit result flags of one item
   typedef struct packed {
      logic content_valid;
      logic field_done;
      logic record_done;
      logic data_done;
      logic column_mismatch;
      logic quote_mismatch;
      logic syntax_error;
   } rsp_flags_type;

endpackage

`default_nettype wire

@@ src/csvfs_parser.sv @@
`default_nettype none

module csvfs_parser #(
   parameter int COLUMN_BITS = csvfs_pkg::DEFAULT_COLUMN_BITS,
   parameter int ROW_BITS    = csvfs_pkg::DEFAULT_ROW_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire logic [7:0]             text_byte,
   input  wire logic                   tab_separated,
   output logic                        emit,
   output logic [7:0]                  content_byte,
   output logic [COLUMN_BITS-1:0]      column_index,
   output logic [ROW_BITS-1:0]         row_index,
   output csvfs_pkg::rsp_flags_type    flags
);

   typedef enum logic [2:0] {
      PS_START,
      PS_QUOTED,
      PS_PLAIN,
      PS_AFTER_CR,
      PS_ERROR
   } parse_state_type;

   parse_state_type        parse_state_ff, parse_state_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   field_quoted_ff, field_quoted_in;
   logic [COLUMN_BITS-1:0] fields_in_record_ff, fields_in_record_in;
   logic [COLUMN_BITS-1:0] first_record_fields_ff, first_record_fields_in;
   logic [ROW_BITS-1:0]    record_counter_ff, record_counter_in;
   logic                   at_record_start_ff, at_record_start_in;

   logic [7:0] sep;
   logic       content;
   logic       end_field;
   logic       end_record;

   // per-item state update and result
   always_comb begin
      sep = tab_separated ? csvfs_pkg::CHAR_TAB : csvfs_pkg::CHAR_COMMA;

      parse_state_in         = parse_state_ff;
      held_byte_in           = held_byte_ff;
      held_valid_in          = held_valid_ff;
      field_quoted_in        = field_quoted_ff;
      fields_in_record_in    = fields_in_record_ff;
      first_record_fields_in = first_record_fields_ff;
      record_counter_in      = record_counter_ff;
      at_record_start_in     = at_record_start_ff;

      flags        = '0;
      content_byte = '0;
      emit         = 1'b0;
      content      = 1'b0;
      end_field    = 1'b0;
      end_record   = 1'b0;
      column_index = fields_in_record_ff;
      row_index    = record_counter_ff;

      if (parse_state_ff == PS_ERROR) begin
         if (text_byte == csvfs_pkg::CHAR_END) begin
            flags.data_done = 1'b1;
            emit            = 1'b1;
         end
      end else if (text_byte == csvfs_pkg::CHAR_END && at_record_start_ff) begin
         // end marker right after a line end: no record closed
         flags.data_done = 1'b1;
         emit            = 1'b1;
      end else begin
         at_record_start_in = 1'b0;
         case (parse_state_ff)
            PS_QUOTED: begin
               if (text_byte == csvfs_pkg::CHAR_QUOTE) begin
                  parse_state_in = PS_PLAIN;
                  content        = 1'b1;
               end else if (text_byte == csvfs_pkg::CHAR_END) begin
                  parse_state_in  = PS_ERROR;
                  flags.data_done = 1'b1;
                  emit            = 1'b1;
               end else begin
                  content = 1'b1;
               end
            end
            PS_AFTER_CR: begin
               if (text_byte == csvfs_pkg::CHAR_LF) begin
                  end_field  = 1'b1;
                  end_record = 1'b1;
               end else begin
                  // bare CR
                  parse_state_in  = PS_ERROR;
                  emit            = 1'b1;
                  flags.data_done = (text_byte == csvfs_pkg::CHAR_END);
               end
            end
            default: begin
               if (text_byte == sep) begin
                  end_field = 1'b1;
               end else if (text_byte == csvfs_pkg::CHAR_CR) begin
                  parse_state_in = PS_AFTER_CR;
               end else if (text_byte == csvfs_pkg::CHAR_LF) begin
                  end_field  = 1'b1;
                  end_record = 1'b1;
               end else if (text_byte == csvfs_pkg::CHAR_END) begin
                  end_field       = 1'b1;
                  end_record      = 1'b1;
                  flags.data_done = 1'b1;
               end else if (parse_state_ff == PS_START &&
                            text_byte == csvfs_pkg::CHAR_QUOTE) begin
                  parse_state_in  = PS_QUOTED;
                  field_quoted_in = !tab_separated;
                  content         = tab_separated;
               end else begin
                  parse_state_in = PS_PLAIN;
                  content        = 1'b1;
               end
            end
         endcase
      end

      // content byte, through the one-byte hold for stripped quoted fields
      if (content) begin
         if (field_quoted_in) begin
            if (held_valid_ff) begin
               content_byte        = held_byte_ff;
               flags.content_valid = 1'b1;
               emit                = 1'b1;
            end
            held_byte_in  = text_byte;
            held_valid_in = 1'b1;
         end else begin
            content_byte        = text_byte;
            flags.content_valid = 1'b1;
            emit                = 1'b1;
         end
      end

      // field end
      if (end_field) begin
         flags.field_done = 1'b1;
         emit             = 1'b1;
         if (field_quoted_ff) begin
            flags.quote_mismatch = !(held_valid_ff &&
                                     held_byte_ff == csvfs_pkg::CHAR_QUOTE);
         end
         held_byte_in    = '0;
         held_valid_in   = 1'b0;
         field_quoted_in = 1'b0;
         parse_state_in  = PS_START;
         if (fields_in_record_ff != '1) begin
            fields_in_record_in = fields_in_record_ff + 1'b1;
         end
      end

      // record end: compare the field count against the first record
      if (end_record) begin
         flags.record_done = 1'b1;
         if (record_counter_ff == '0) begin
            first_record_fields_in = fields_in_record_in;
         end else begin
            flags.column_mismatch = (fields_in_record_in != first_record_fields_ff);
         end
         if (record_counter_ff != '1) begin
            record_counter_in = record_counter_ff + 1'b1;
         end
         fields_in_record_in = '0;
         at_record_start_in  = 1'b1;
      end

      flags.syntax_error = (parse_state_in == PS_ERROR);

      // end of data starts a fresh stream
      if (flags.data_done) begin
         parse_state_in         = PS_START;
         held_byte_in           = '0;
         held_valid_in          = 1'b0;
         field_quoted_in        = 1'b0;
         fields_in_record_in    = '0;
         first_record_fields_in = '0;
         record_counter_in      = '0;
         at_record_start_in     = 1'b0;
      end
   end

   // stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_state_ff         <= PS_START;
         held_byte_ff           <= '0;
         held_valid_ff          <= 1'b0;
         field_quoted_ff        <= 1'b0;
         fields_in_record_ff    <= '0;
         first_record_fields_ff <= '0;
         record_counter_ff      <= '0;
         at_record_start_ff     <= 1'b0;
      end else if (step_en) begin
         parse_state_ff         <= parse_state_in;
         held_byte_ff           <= held_byte_in;
         held_valid_ff          <= held_valid_in;
         field_quoted_ff        <= field_quoted_in;
         fields_in_record_ff    <= fields_in_record_in;
         first_record_fields_ff <= first_record_fields_in;
         record_counter_ff      <= record_counter_in;
         at_record_start_ff     <= at_record_start_in;
      end
   end

endmodule

`default_nettype wire

@@ src/csv_field_splitter.sv @@
// CSV field splitter.
// Input channel (req_): one text byte per item, byte 0 marks end of data.
// Result channel (rsp_): zero or one result per input item carrying a
// content byte and/or field, record and end-of-data marks with column and
// row indices and error flags. Items that produce nothing (a CR, or the
// opening quote of a stripped quoted field) give no result.
// Configuration: csr_wr_en writes csr_wr_data into tab_separated; write it
// only while the block is idle.
// Path: an accepted item goes into the input register, and the parse logic
// writes its result into the result register that drives the rsp_ ports.
// Throughput: one item per cycle unless rsp_stall holds a result.
// Stall: while rsp_stall holds a result, one more item is taken into the
// input register; req_stall then rises until the result is taken.
// Reset: synchronous, clears the pipeline valids, the parse state and the
// counters, and sets tab_separated to 0 (comma mode). No clearing pass.
`default_nettype none

module csv_field_splitter #(
   parameter int COLUMN_BITS = csvfs_pkg::DEFAULT_COLUMN_BITS,
   parameter int ROW_BITS    = csvfs_pkg::DEFAULT_ROW_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_text_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_content_byte,
   output logic                        rsp_content_valid,
   output logic                        rsp_field_done,
   output logic                        rsp_record_done,
   output logic                        rsp_data_done,
   output logic [COLUMN_BITS-1:0]      rsp_column_index,
   output logic [ROW_BITS-1:0]         rsp_row_index,
   output logic                        rsp_column_mismatch,
   output logic                        rsp_quote_mismatch,
   output logic                        rsp_syntax_error
);

   logic                     tab_separated_ff;
   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff;
   logic [COLUMN_BITS-1:0]   rsp_column_ff;
   logic [ROW_BITS-1:0]      rsp_row_ff;
   csvfs_pkg::rsp_flags_type rsp_flags_ff;

   logic                     out_free;
   logic                     step_en;
   logic                     req_accept;
   logic                     emit;
   logic [7:0]               step_byte;
   logic [COLUMN_BITS-1:0]   step_column;
   logic [ROW_BITS-1:0]      step_row;
   csvfs_pkg::rsp_flags_type step_flags;

   // handshake control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step_en    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (out_free) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step_en && emit;
      end
   end

   csvfs_parser #(
      .COLUMN_BITS (COLUMN_BITS),
      .ROW_BITS    (ROW_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .text_byte     (in_byte_ff),
      .tab_separated (tab_separated_ff),
      .emit          (emit),
      .content_byte  (step_byte),
      .column_index  (step_column),
      .row_index     (step_row),
      .flags         (step_flags)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_separated_ff <= 1'b0;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tab_separated_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_text_byte;
      end
      if (step_en && emit) begin
         rsp_byte_ff   <= step_byte;
         rsp_column_ff <= step_column;
         rsp_row_ff    <= step_row;
         rsp_flags_ff  <= step_flags;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_content_byte    = rsp_byte_ff;
   assign rsp_content_valid   = rsp_flags_ff.content_valid;
   assign rsp_field_done      = rsp_flags_ff.field_done;
   assign rsp_record_done     = rsp_flags_ff.record_done;
   assign rsp_data_done       = rsp_flags_ff.data_done;
   assign rsp_column_index    = rsp_column_ff;
   assign rsp_row_index       = rsp_row_ff;
   assign rsp_column_mismatch = rsp_flags_ff.column_mismatch;
   assign rsp_quote_mismatch  = rsp_flags_ff.quote_mismatch;
   assign rsp_syntax_error    = rsp_flags_ff.syntax_error;

endmodule

`default_nettype wire

@@ src/csvfs_checker.sv @@
`default_nettype none

module csvfs_checker #(
   parameter int COLUMN_BITS = csvfs_pkg::DEFAULT_COLUMN_BITS,
   parameter int ROW_BITS    = csvfs_pkg::DEFAULT_ROW_BITS
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   csr_wr_en,
   input wire logic                   csr_wr_data,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic [7:0]             req_text_byte,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [7:0]             rsp_content_byte,
   input wire logic                   rsp_content_valid,
   input wire logic                   rsp_field_done,
   input wire logic                   rsp_record_done,
   input wire logic                   rsp_data_done,
   input wire logic [COLUMN_BITS-1:0] rsp_column_index,
   input wire logic [ROW_BITS-1:0]    rsp_row_index,
   input wire logic                   rsp_column_mismatch,
   input wire logic                   rsp_quote_mismatch,
   input wire logic                   rsp_syntax_error
);

   // a record end always closes a field too
   a_record_has_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_done |-> rsp_field_done)
      else $error("record end without field end");

   // field count mismatch only reported on a record end
   a_colmis_on_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_column_mismatch |-> rsp_record_done)
      else $error("column mismatch outside record end");

   // quote mismatch only reported on a field end
   a_qmis_on_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quote_mismatch |-> rsp_field_done)
      else $error("quote mismatch outside field end");

   // content and a field or data end never share an item
   a_content_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_content_valid |-> !rsp_field_done && !rsp_data_done)
      else $error("content byte on a field or data end");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_content_byte) &&
         $stable(rsp_row_index) && $stable(rsp_column_index))
      else $error("stalled result changed");

endmodule

bind csv_field_splitter csvfs_checker #(
   .COLUMN_BITS (COLUMN_BITS),
   .ROW_BITS    (ROW_BITS)
) u_csvfs_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   localparam int COL_W          = csvfs_pkg::DEFAULT_COLUMN_BITS;
   localparam int ROW_W          = csvfs_pkg::DEFAULT_ROW_BITS;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int RANDOM_ITEMS   = 450;
   localparam int MIN_PHASES     = 3;
   localparam int PHASE_ITEMS    = 100;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_GAP        = 18;
   localparam int REPORT_LIMIT   = 10;
   localparam int SAT_FIELDS     = 260;

   // parse states of the splitter model
   typedef enum logic [2:0] {
      SPLIT_FIELD_START,
      SPLIT_IN_QUOTES,
      SPLIT_IN_FIELD,
      SPLIT_SAW_CR,
      SPLIT_FAULT
   } split_state_type;

   typedef struct packed {
      logic [7:0]       content_byte;
      logic             content_valid;
      logic             field_done;
      logic             record_done;
      logic             data_done;
      logic [COL_W-1:0] column_index;
      logic [ROW_W-1:0] row_index;
      logic             column_mismatch;
      logic             quote_mismatch;
      logic             syntax_error;
   } split_result_type;

   typedef struct {
      logic [7:0]       text;
      logic             typed;
      split_result_type result;
   } split_row_type;

   // DUT ports
   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             csr_wr_en     = 1'b0;
   logic             csr_wr_data   = 1'b0;
   logic             req_valid     = 1'b0;
   logic             req_stall;
   logic [7:0]       req_text_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall     = 1'b0;
   logic [7:0]       rsp_content_byte;
   logic             rsp_content_valid;
   logic             rsp_field_done;
   logic             rsp_record_done;
   logic             rsp_data_done;
   logic [COL_W-1:0] rsp_column_index;
   logic [ROW_W-1:0] rsp_row_index;
   logic             rsp_column_mismatch;
   logic             rsp_quote_mismatch;
   logic             rsp_syntax_error;

   // traffic shaping
   logic             idle_tx        = 1'b0;
   logic             idle_rx        = 1'b0;
   logic             rsp_hold       = 1'b0;
   logic             hold_start     = 1'b0;
   int               rsp_wait       = 0;

   // bookkeeping
   int               cycle_count    = 0;
   int               mismatch_count = 0;
   int               results_seen   = 0;
   int               records_seen   = 0;
   int               items_sent     = 0;
   split_result_type pending_results[$];
   split_result_type seen_result;
   logic [7:0]       stream_bytes[$];
   split_row_type    directed_rows[$];

   // splitter model state
   logic             mdl_tab;
   split_state_type  mdl_state;
   logic [7:0]       mdl_held;
   logic             mdl_held_valid;
   logic             mdl_quoted;
   logic [COL_W-1:0] mdl_fields;
   logic [COL_W-1:0] mdl_first_fields;
   logic [ROW_W-1:0] mdl_rows;
   logic             mdl_rec_start;

   csv_field_splitter #(
      .COLUMN_BITS(COL_W),
      .ROW_BITS(ROW_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_content_byte(rsp_content_byte),
      .rsp_content_valid(rsp_content_valid),
      .rsp_field_done(rsp_field_done),
      .rsp_record_done(rsp_record_done),
      .rsp_data_done(rsp_data_done),
      .rsp_column_index(rsp_column_index),
      .rsp_row_index(rsp_row_index),
      .rsp_column_mismatch(rsp_column_mismatch),
      .rsp_quote_mismatch(rsp_quote_mismatch),
      .rsp_syntax_error(rsp_syntax_error)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stream state back to its reset values; the mode register is kept
   task automatic restart_stream();
      mdl_state        = SPLIT_FIELD_START;
      mdl_held         = 8'h00;
      mdl_held_valid   = 1'b0;
      mdl_quoted       = 1'b0;
      mdl_fields       = '0;
      mdl_first_fields = '0;
      mdl_rows         = '0;
      mdl_rec_start    = 1'b0;
   endtask

   // one text byte through the splitter model
   task automatic split_byte(input logic [7:0] b, output logic emit,
                             output split_result_type r);
      logic [7:0] sep;
      logic       end_field;
      logic       end_record;
      logic       content;
      sep        = mdl_tab ? csvfs_pkg::CHAR_TAB : csvfs_pkg::CHAR_COMMA;
      r          = '0;
      emit       = 1'b0;
      end_field  = 1'b0;
      end_record = 1'b0;
      content    = 1'b0;
      r.column_index = mdl_fields;
      r.row_index    = mdl_rows;

      if (mdl_state == SPLIT_FAULT) begin
         // only the end marker gets out of the error state
         if (b == csvfs_pkg::CHAR_END) begin
            r.data_done = 1'b1;
            emit = 1'b1;
         end
      end else if (b == csvfs_pkg::CHAR_END && mdl_rec_start) begin
         // end right after a line end closes no record
         r.data_done = 1'b1;
         emit = 1'b1;
      end else begin
         mdl_rec_start = 1'b0;
         case (mdl_state)
            SPLIT_IN_QUOTES: begin
               if (b == csvfs_pkg::CHAR_QUOTE) begin
                  mdl_state = SPLIT_IN_FIELD;
                  content = 1'b1;
               end else if (b == csvfs_pkg::CHAR_END) begin
                  mdl_state = SPLIT_FAULT;
                  r.data_done = 1'b1;
                  emit = 1'b1;
               end else begin
                  content = 1'b1;
               end
            end
            SPLIT_SAW_CR: begin
               if (b == csvfs_pkg::CHAR_LF) begin
                  end_field = 1'b1;
                  end_record = 1'b1;
               end else begin
                  mdl_state = SPLIT_FAULT;
                  emit = 1'b1;
                  r.data_done = (b == csvfs_pkg::CHAR_END);
               end
            end
            default: begin
               if (b == sep) begin
                  end_field = 1'b1;
               end else if (b == csvfs_pkg::CHAR_CR) begin
                  mdl_state = SPLIT_SAW_CR;
               end else if (b == csvfs_pkg::CHAR_LF) begin
                  end_field = 1'b1;
                  end_record = 1'b1;
               end else if (b == csvfs_pkg::CHAR_END) begin
                  end_field = 1'b1;
                  end_record = 1'b1;
                  r.data_done = 1'b1;
               end else if (mdl_state == SPLIT_FIELD_START &&
                            b == csvfs_pkg::CHAR_QUOTE) begin
                  // stripping is fixed when the field opens
                  mdl_state = SPLIT_IN_QUOTES;
                  mdl_quoted = !mdl_tab;
                  content = mdl_tab;
               end else begin
                  mdl_state = SPLIT_IN_FIELD;
                  content = 1'b1;
               end
            end
         endcase
      end

      // quoted fields go through the one-byte hold
      if (content) begin
         if (mdl_quoted) begin
            if (mdl_held_valid) begin
               r.content_byte = mdl_held;
               r.content_valid = 1'b1;
               emit = 1'b1;
            end
            mdl_held = b;
            mdl_held_valid = 1'b1;
         end else begin
            r.content_byte = b;
            r.content_valid = 1'b1;
            emit = 1'b1;
         end
      end

      if (end_field) begin
         r.field_done = 1'b1;
         emit = 1'b1;
         if (mdl_quoted)
            r.quote_mismatch = !(mdl_held_valid && mdl_held == csvfs_pkg::CHAR_QUOTE);
         mdl_held = 8'h00;
         mdl_held_valid = 1'b0;
         mdl_quoted = 1'b0;
         mdl_state = SPLIT_FIELD_START;
         if (mdl_fields != '1)
            mdl_fields++;
      end

      if (end_record) begin
         r.record_done = 1'b1;
         if (mdl_rows == '0)
            mdl_first_fields = mdl_fields;
         else
            r.column_mismatch = (mdl_fields != mdl_first_fields);
         if (mdl_rows != '1)
            mdl_rows++;
         mdl_fields = '0;
         mdl_rec_start = 1'b1;
      end

      r.syntax_error = (mdl_state == SPLIT_FAULT);
      if (r.data_done)
         restart_stream();
   endtask

   function automatic string show_result(split_result_type r);
      return $sformatf({"byte=%02h cv=%0b fd=%0b rd=%0b dd=%0b col=%0d row=%0d ",
                        "cmis=%0b qmis=%0b err=%0b"},
                       r.content_byte, r.content_valid, r.field_done, r.record_done,
                       r.data_done, r.column_index, r.row_index, r.column_mismatch,
                       r.quote_mismatch, r.syntax_error);
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // send one item, then predict it once accepted
   task automatic feed_byte(input logic [7:0] b, input logic typed,
                            input split_result_type fixed);
      int               gap;
      logic             emit;
      split_result_type predicted;
      gap = idle_tx ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      split_byte(b, emit, predicted);
      if (typed)
         pending_results.push_back(fixed);
      else if (emit)
         pending_results.push_back(predicted);
   endtask

   // wait out every expected result plus the pipeline
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic tab);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tab;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mdl_tab = tab;
   endtask

   task automatic add_row(input logic [7:0] b, input logic typed,
                          input split_result_type r);
      split_row_type row;
      row.text   = b;
      row.typed  = typed;
      row.result = r;
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      if (b == csvfs_pkg::CHAR_TAB || b == csvfs_pkg::CHAR_LF ||
          b == csvfs_pkg::CHAR_CR || b == csvfs_pkg::CHAR_QUOTE ||
          b == csvfs_pkg::CHAR_COMMA)
         b = 8'h41;
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return csvfs_pkg::CHAR_CR;
         1: return csvfs_pkg::CHAR_LF;
         2: return csvfs_pkg::CHAR_QUOTE;
         3: return csvfs_pkg::CHAR_COMMA;
         4: return csvfs_pkg::CHAR_TAB;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed records with random content, some noise
   task automatic build_stream(input logic [7:0] sep, input logic [7:0] other_sep);
      int n_rec;
      int n_fld;
      int fields;
      int len;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, 12);
         repeat (len) stream_bytes.push_back(noise_byte());
      end else begin
         n_rec = $urandom_range(1, 4);
         n_fld = $urandom_range(1, 4);
         repeat (n_rec) begin
            fields = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : n_fld;
            for (int f = 0; f < fields; f++) begin
               if (f > 0)
                  stream_bytes.push_back(($urandom_range(0, 15) == 0) ? other_sep : sep);
               case ($urandom_range(0, 9))
                  0, 1: ;
                  2, 3, 4, 5: begin
                     len = $urandom_range(1, 5);
                     repeat (len) stream_bytes.push_back(plain_byte());
                  end
                  6, 7, 8: begin
                     stream_bytes.push_back(csvfs_pkg::CHAR_QUOTE);
                     len = $urandom_range(0, 5);
                     repeat (len) begin
                        case ($urandom_range(0, 7))
                           0: stream_bytes.push_back(sep);
                           1: stream_bytes.push_back(other_sep);
                           2: stream_bytes.push_back(csvfs_pkg::CHAR_CR);
                           3: stream_bytes.push_back(csvfs_pkg::CHAR_LF);
                           default: stream_bytes.push_back(plain_byte());
                        endcase
                     end
                     // end of data inside quotes, now and then
                     if ($urandom_range(0, 29) == 0)
                        stream_bytes.push_back(csvfs_pkg::CHAR_END);
                     if ($urandom_range(0, 9) != 0)
                        stream_bytes.push_back(csvfs_pkg::CHAR_QUOTE);
                     if ($urandom_range(0, 3) == 0)
                        stream_bytes.push_back(($urandom_range(0, 1)) ?
                                               csvfs_pkg::CHAR_QUOTE : plain_byte());
                  end
                  default: stream_bytes.push_back(noise_byte());
               endcase
            end
            // line end: LF, CRLF, or a bare CR now and then
            if ($urandom_range(0, 19) == 0) begin
               stream_bytes.push_back(csvfs_pkg::CHAR_CR);
               stream_bytes.push_back(plain_byte());
            end else begin
               if ($urandom_range(0, 1))
                  stream_bytes.push_back(csvfs_pkg::CHAR_CR);
               stream_bytes.push_back(csvfs_pkg::CHAR_LF);
            end
         end
      end
      if ($urandom_range(0, 7) != 0)
         stream_bytes.push_back(csvfs_pkg::CHAR_END);
   endtask

   // result side: random stall per result, long hold from its own process
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.content_byte    = rsp_content_byte;
         seen_result.content_valid   = rsp_content_valid;
         seen_result.field_done      = rsp_field_done;
         seen_result.record_done     = rsp_record_done;
         seen_result.data_done       = rsp_data_done;
         seen_result.column_index    = rsp_column_index;
         seen_result.row_index       = rsp_row_index;
         seen_result.column_mismatch = rsp_column_mismatch;
         seen_result.quote_mismatch  = rsp_quote_mismatch;
         seen_result.syntax_error    = rsp_syntax_error;
         results_seen++;
         if (rsp_record_done)
            records_seen++;
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("UNEXPECTED result at cycle %0d: %s",
                                    cycle_count, show_result(seen_result)));
         end else if (pending_results[0] !== seen_result) begin
            flag_mismatch($sformatf("MISMATCH at cycle %0d: expected %s, got %s",
                                    cycle_count, show_result(pending_results[0]),
                                    show_result(seen_result)));
            void'(pending_results.pop_front());
         end else begin
            void'(pending_results.pop_front());
         end
         rsp_wait <= idle_rx ? $urandom_range(0, MAX_GAP) : 0;
         rsp_stall <= rsp_hold || (idle_rx && rsp_wait > 0);
      end else begin
         if (rsp_valid && rsp_wait > 0)
            rsp_wait <= rsp_wait - 1;
         rsp_stall <= rsp_hold || (rsp_wait > 1) || (rsp_wait == 1 && !rsp_valid);
      end
   end

   initial begin
      wait (hold_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      split_result_type none;
      split_result_type r_empty;
      split_result_type r_ff;
      split_result_type r_err;
      split_result_type r_err_end;
      int               phases;
      int               tab_phases;
      int               phase_items;
      int               random_sent;
      logic             tab;

      none = '0;
      mdl_tab = 1'b0;
      restart_stream();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, comma mode
      r_empty = '0;
      r_empty.field_done  = 1'b1;
      r_empty.record_done = 1'b1;
      r_empty.data_done   = 1'b1;
      r_ff = '0;
      r_ff.content_byte  = 8'hFF;
      r_ff.content_valid = 1'b1;
      r_err = '0;
      r_err.syntax_error = 1'b1;
      r_err_end = r_err;
      r_err_end.data_done = 1'b1;

      add_row(csvfs_pkg::CHAR_END,   1'b1, r_empty);   // empty input: one empty record
      add_row(8'hFF,                 1'b1, r_ff);
      add_row(csvfs_pkg::CHAR_COMMA, 1'b0, none);
      add_row(csvfs_pkg::CHAR_QUOTE, 1'b0, none);      // opening quote is dropped
      add_row(csvfs_pkg::CHAR_COMMA, 1'b0, none);      // separator inside quotes
      add_row(csvfs_pkg::CHAR_QUOTE, 1'b0, none);
      add_row(csvfs_pkg::CHAR_LF,    1'b0, none);
      add_row(8'h01,                 1'b0, none);      // short record: column mismatch
      add_row(csvfs_pkg::CHAR_CR,    1'b0, none);
      add_row(csvfs_pkg::CHAR_LF,    1'b0, none);
      add_row(csvfs_pkg::CHAR_COMMA, 1'b0, none);      // empty field before CRLF
      add_row(csvfs_pkg::CHAR_CR,    1'b0, none);
      add_row(csvfs_pkg::CHAR_LF,    1'b0, none);
      add_row(csvfs_pkg::CHAR_QUOTE, 1'b0, none);      // quoted field, no closing quote
      add_row(8'h61,                 1'b0, none);
      add_row(csvfs_pkg::CHAR_LF,    1'b0, none);
      add_row(8'h62,                 1'b0, none);
      add_row(csvfs_pkg::CHAR_COMMA, 1'b0, none);
      add_row(csvfs_pkg::CHAR_LF,    1'b0, none);
      add_row(csvfs_pkg::CHAR_END,   1'b0, none);      // end inside the still-open quotes
      add_row(8'h7A,                 1'b0, none);
      add_row(csvfs_pkg::CHAR_CR,    1'b0, none);
      add_row(8'h71,                 1'b1, r_err);     // bare CR
      add_row(8'h72,                 1'b0, none);      // ignored while in error
      add_row(csvfs_pkg::CHAR_END,   1'b1, r_err_end);
      add_row(csvfs_pkg::CHAR_QUOTE, 1'b0, none);
      add_row(csvfs_pkg::CHAR_END,   1'b1, r_err_end); // end inside quotes

      write_mode(1'b0);
      idle_tx = 1'b1;
      idle_rx = 1'b1;
      foreach (directed_rows[i])
         feed_byte(directed_rows[i].text, directed_rows[i].typed, directed_rows[i].result);
      drain();

      // random phases, mode and idling change between phases
      phases = 0;
      tab_phases = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS || phases < MIN_PHASES) begin
         tab = (phases < 2) ? phases[0] : 1'($urandom_range(0, 1));
         write_mode(tab);
         if (tab)
            tab_phases++;
         if (phases == 2) begin
            // long output hold with a steady sender
            idle_tx = 1'b0;
            idle_rx = 1'b0;
            hold_start = 1'b1;
         end else begin
            idle_tx = ($urandom_range(0, 3) != 0);
            idle_rx = ($urandom_range(0, 3) != 0);
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            build_stream(tab ? csvfs_pkg::CHAR_TAB : csvfs_pkg::CHAR_COMMA,
                         tab ? csvfs_pkg::CHAR_COMMA : csvfs_pkg::CHAR_TAB);
            while (stream_bytes.size() != 0) begin
               feed_byte(stream_bytes.pop_front(), 1'b0, none);
               phase_items++;
            end
         end
         random_sent += phase_items;
         phases++;
         drain();
      end

      // column counter up to saturation, no idling
      write_mode(1'b0);
      idle_tx = 1'b0;
      idle_rx = 1'b0;
      feed_byte(csvfs_pkg::CHAR_END, 1'b0, none);  // leave any open stream
      repeat (SAT_FIELDS) feed_byte(csvfs_pkg::CHAR_COMMA, 1'b0, none);
      feed_byte(csvfs_pkg::CHAR_LF, 1'b0, none);
      feed_byte(csvfs_pkg::CHAR_END, 1'b0, none);
      drain();

      $display("Sent %0d items (%0d directed, %0d random in %0d phases, %0d in tab mode)",
               items_sent, directed_rows.size(), random_sent, phases, tab_phases);
      $display("Checked %0d results, %0d records, incl. column saturation and output hold",
               results_seen, records_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/csvfs_pkg.sv
src/csvfs_parser.sv
src/csv_field_splitter.sv
src/csvfs_checker.sv
tb/testbench.sv
